/* rtl/tts_pkg.sv */
package tts_pkg;

	// operation codes carried by func
	localparam logic [2:0] FUNC_ALLOC   = 3'd0;
	localparam logic [2:0] FUNC_SLEEP   = 3'd1;
	localparam logic [2:0] FUNC_TICK    = 3'd2;
	localparam logic [2:0] FUNC_PICK    = 3'd3;
	localparam logic [2:0] FUNC_RELEASE = 3'd4;

	// result status codes
	localparam logic [1:0] STATUS_OK       = 2'd0;
	localparam logic [1:0] STATUS_NO_FREE  = 2'd1;
	localparam logic [1:0] STATUS_NO_RUN   = 2'd2;
	localparam logic [1:0] STATUS_BAD_SLOT = 2'd3;

	// per-slot state codes, code 3 reads as free
	localparam logic [1:0] SLOT_FREE  = 2'd0;
	localparam logic [1:0] SLOT_RUN   = 2'd1;
	localparam logic [1:0] SLOT_SLEEP = 2'd2;

	// controller to datapath
	typedef struct packed {
		logic clear;
		logic accept;
		logic prime;
		logic scan;
		logic single;
		logic deliver;
	} tts_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic clear_last;
		logic op_scan;
		logic op_single;
		logic scan_done;
		logic out_free;
	} tts_sts_t;

endpackage

/* rtl/task_table_round_robin_sleep_scheduler.sv */
// round-robin task scheduler with sleep timers. one transaction in gives exactly one
// transaction out. the slot table (state code plus tick counter per slot) lives in a
// single-port-write, registered-read RAM; allocate, tick and pick walk it one slot per
// cycle, while sleep and release touch only the named slot. allocate and pick stop at
// the first hit, tick always walks the whole table. the next transaction can be
// accepted in the cycle after the result lands in the output register. one operation
// is in flight at a time; the output register lets the next transaction be accepted
// while a result still waits for out_ready. after reset the block clears every slot of
// the table to free and holds in_ready low meanwhile. granted_slot carries the low 8
// bits of the slot index; sleep_ticks is taken modulo 2^TICK_BITS.
module task_table_round_robin_sleep_scheduler #(
	parameter int NUM_SLOTS = 256,
	parameter int TICK_BITS = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	// request channel
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [2:0]  func,
	input  logic [7:0]  slot,
	input  logic [31:0] sleep_ticks,
	// result channel
	output logic        out_valid,
	input  logic        out_ready,
	output logic [1:0]  status,
	output logic [7:0]  granted_slot,
	output logic        preempted
);

	tts_pkg::tts_cmd_t cmd;
	tts_pkg::tts_sts_t sts;

	// sequencer: clear pass, accept, table walk, hand-off to output register
	tts_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	// slot table, scan pointers, current task and output register
	tts_dp #(
		.NUM_SLOTS (NUM_SLOTS),
		.TICK_BITS (TICK_BITS)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.sts          (sts),
		.func         (func),
		.slot         (slot),
		.sleep_ticks  (sleep_ticks),
		.out_ready    (out_ready),
		.out_valid    (out_valid),
		.status       (status),
		.granted_slot (granted_slot),
		.preempted    (preempted)
	);

`ifndef ASSERT_OFF
	// one operation at a time: accepting a transaction drops ready next cycle
	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> !in_ready)
		else $error("second transaction accepted while one is in flight");

	// at most one command per cycle from the sequencer
	a_cmd_onehot: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0({cmd.clear, cmd.accept, cmd.prime, cmd.scan, cmd.single, cmd.deliver}))
		else $error("sequencer issued overlapping commands");

	// a result shows up only after the sequencer handed one over
	a_out_from_deliver: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(cmd.deliver))
		else $error("result valid without a delivery");

	// preemption is only reported on a successful tick
	a_preempt_ok: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && preempted) |-> (status == tts_pkg::STATUS_OK))
		else $error("preemption reported with an error status");
`endif

endmodule

/* rtl/tts_ram.sv */
module tts_ram #(
	parameter int WIDTH = 34,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

/* rtl/tts_ctrl.sv */
module tts_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  tts_pkg::tts_sts_t  sts,
	output tts_pkg::tts_cmd_t  cmd
);

	localparam logic [2:0] S_CLEAR  = 3'd0;
	localparam logic [2:0] S_IDLE   = 3'd1;
	localparam logic [2:0] S_PRIME  = 3'd2;
	localparam logic [2:0] S_SCAN   = 3'd3;
	localparam logic [2:0] S_SINGLE = 3'd4;
	localparam logic [2:0] S_DONE   = 3'd5;

	logic [2:0] state_q;
	logic [2:0] state_d;

	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		in_ready = 1'b0;
		unique case (state_q)
			S_CLEAR: begin
				cmd.clear = 1'b1;
				if (sts.clear_last) begin
					state_d = S_IDLE;
				end
			end
			S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.accept = 1'b1;
					state_d    = S_PRIME;
				end
			end
			S_PRIME: begin
				cmd.prime = 1'b1;
				if (sts.op_scan) begin
					state_d = S_SCAN;
				end else if (sts.op_single) begin
					state_d = S_SINGLE;
				end else begin
					state_d = S_DONE;
				end
			end
			S_SCAN: begin
				cmd.scan = 1'b1;
				if (sts.scan_done) begin
					state_d = S_DONE;
				end
			end
			S_SINGLE: begin
				cmd.single = 1'b1;
				state_d    = S_DONE;
			end
			S_DONE: begin
				if (sts.out_free) begin
					cmd.deliver = 1'b1;
					state_d     = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

/* rtl/tts_dp.sv */
module tts_dp #(
	parameter int NUM_SLOTS = 256,
	parameter int TICK_BITS = 32
) (
	input  logic               clk,
	input  logic               arst_n,
	input  tts_pkg::tts_cmd_t  cmd,
	output tts_pkg::tts_sts_t  sts,
	input  logic [2:0]         func,
	input  logic [7:0]         slot,
	input  logic [31:0]        sleep_ticks,
	input  logic               out_ready,
	output logic               out_valid,
	output logic [1:0]         status,
	output logic [7:0]         granted_slot,
	output logic               preempted
);

	localparam int SW  = $clog2(NUM_SLOTS);
	localparam int XW  = ((SW > 8) ? SW : 8) + 1;
	localparam int STW = TICK_BITS + 2;
	localparam logic [SW-1:0]        LAST_IDX = SW'(NUM_SLOTS - 1);
	localparam logic [TICK_BITS-1:0] CNT_ZERO = '0;

	// op registers
	logic [2:0]           func_q;
	logic [TICK_BITS-1:0] ticks_q;
	logic                 slot_ok_q;

	// address and scan control
	logic [SW-1:0] addr_q;
	logic [SW-1:0] eaddr_q;
	logic [SW-1:0] step_q;
	logic [SW-1:0] scan_pos_q;
	logic          cur_valid_q;
	logic [SW-1:0] cur_slot_q;

	// result being built and output register
	logic [1:0] res_status_q;
	logic [7:0] res_granted_q;
	logic       res_pre_q;
	logic       out_valid_q;
	logic [1:0] status_q;
	logic [7:0] granted_q;
	logic       preempted_q;

	logic [XW-1:0]        slot_x;
	logic                 slot_ok;
	logic [SW-1:0]        start_addr;
	logic [SW-1:0]        addr_next;
	logic [SW-1:0]        eaddr_next;
	logic [XW-1:0]        eaddr_x;
	logic                 step_last;
	logic [STW-1:0]       rdata;
	logic [1:0]           st;
	logic [TICK_BITS-1:0] cnt;
	logic [TICK_BITS-1:0] cnt_dec;
	logic                 taken;
	logic                 hit;
	logic                 we;
	logic [SW-1:0]        waddr;
	logic [STW-1:0]       wdata;

	tts_ram #(
		.WIDTH (STW),
		.DEPTH (NUM_SLOTS)
	) u_ram (
		.clk   (clk),
		.we    (we),
		.waddr (waddr),
		.wdata (wdata),
		.raddr (addr_q),
		.rdata (rdata)
	);

	assign slot_x     = XW'(slot);
	assign slot_ok    = slot_x < XW'(NUM_SLOTS);
	assign addr_next  = (addr_q == LAST_IDX) ? '0 : addr_q + 1'b1;
	assign eaddr_next = (eaddr_q == LAST_IDX) ? '0 : eaddr_q + 1'b1;
	assign eaddr_x    = XW'(eaddr_q);
	assign step_last  = step_q == LAST_IDX;

	assign st      = rdata[1:0];
	assign cnt     = rdata[STW-1:2];
	assign cnt_dec = cnt - 1'b1;
	assign taken   = (st == tts_pkg::SLOT_RUN) || (st == tts_pkg::SLOT_SLEEP);

	always_comb begin
		unique case (func)
			tts_pkg::FUNC_PICK:    start_addr = scan_pos_q;
			tts_pkg::FUNC_SLEEP,
			tts_pkg::FUNC_RELEASE: start_addr = slot_x[SW-1:0];
			default:               start_addr = '0;
		endcase
	end

	// slot table write and scan hit
	always_comb begin
		we    = 1'b0;
		waddr = eaddr_q;
		wdata = {CNT_ZERO, tts_pkg::SLOT_FREE};
		hit   = 1'b0;
		if (cmd.clear) begin
			we    = 1'b1;
			waddr = addr_q;
		end else if (cmd.scan) begin
			unique case (func_q)
				tts_pkg::FUNC_ALLOC: begin
					if (!taken) begin
						hit   = 1'b1;
						we    = 1'b1;
						wdata = {CNT_ZERO, tts_pkg::SLOT_RUN};
					end
				end
				tts_pkg::FUNC_TICK: begin
					if (st == tts_pkg::SLOT_SLEEP) begin
						we    = 1'b1;
						wdata = {cnt_dec, (cnt_dec == CNT_ZERO) ? tts_pkg::SLOT_RUN
							: tts_pkg::SLOT_SLEEP};
					end
				end
				tts_pkg::FUNC_PICK: begin
					hit = st == tts_pkg::SLOT_RUN;
				end
				default: begin
				end
			endcase
		end else if (cmd.single && slot_ok_q && taken) begin
			we = 1'b1;
			if (func_q == tts_pkg::FUNC_RELEASE) begin
				wdata = {CNT_ZERO, tts_pkg::SLOT_FREE};
			end else if (ticks_q == CNT_ZERO) begin
				wdata = {ticks_q, tts_pkg::SLOT_RUN};
			end else begin
				wdata = {ticks_q, tts_pkg::SLOT_SLEEP};
			end
		end
	end

	assign sts.clear_last = addr_q == LAST_IDX;
	assign sts.op_scan    = (func_q == tts_pkg::FUNC_ALLOC) || (func_q == tts_pkg::FUNC_TICK)
		|| (func_q == tts_pkg::FUNC_PICK);
	assign sts.op_single  = (func_q == tts_pkg::FUNC_SLEEP)
		|| (func_q == tts_pkg::FUNC_RELEASE);
	assign sts.scan_done  = hit || step_last;
	assign sts.out_free   = !out_valid_q || out_ready;

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			addr_q      <= '0;
			step_q      <= '0;
			scan_pos_q  <= '0;
			cur_valid_q <= 1'b0;
			cur_slot_q  <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.clear) begin
				addr_q <= addr_next;
			end else if (cmd.accept) begin
				addr_q <= start_addr;
				step_q <= '0;
			end else if (cmd.prime) begin
				addr_q <= addr_next;
			end else if (cmd.scan) begin
				addr_q <= addr_next;
				step_q <= step_q + 1'b1;
				if (hit && (func_q == tts_pkg::FUNC_PICK)) begin
					cur_valid_q <= 1'b1;
					cur_slot_q  <= eaddr_q;
					scan_pos_q  <= eaddr_next;
				end else if (!hit && step_last && ((func_q == tts_pkg::FUNC_PICK)
					|| (func_q == tts_pkg::FUNC_TICK))) begin
					cur_valid_q <= 1'b0;
				end
			end else if (cmd.single) begin
				if (slot_ok_q && taken && (func_q == tts_pkg::FUNC_RELEASE)
					&& cur_valid_q && (cur_slot_q == eaddr_q)) begin
					cur_valid_q <= 1'b0;
				end
			end
			if (cmd.deliver) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// operation payload and results
	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			func_q        <= func;
			ticks_q       <= TICK_BITS'(sleep_ticks);
			slot_ok_q     <= slot_ok;
			res_status_q  <= tts_pkg::STATUS_OK;
			res_granted_q <= '0;
			res_pre_q     <= 1'b0;
		end
		if (cmd.prime || cmd.scan) begin
			eaddr_q <= addr_q;
		end
		if (cmd.scan) begin
			if (hit) begin
				res_granted_q <= eaddr_x[7:0];
			end else if (step_last) begin
				unique case (func_q)
					tts_pkg::FUNC_ALLOC: res_status_q <= tts_pkg::STATUS_NO_FREE;
					tts_pkg::FUNC_PICK:  res_status_q <= tts_pkg::STATUS_NO_RUN;
					tts_pkg::FUNC_TICK:  res_pre_q    <= cur_valid_q;
					default: begin
					end
				endcase
			end
		end
		if (cmd.single && !(slot_ok_q && taken)) begin
			res_status_q <= tts_pkg::STATUS_BAD_SLOT;
		end
		if (cmd.deliver) begin
			status_q    <= res_status_q;
			granted_q   <= res_granted_q;
			preempted_q <= res_pre_q;
		end
	end

	assign out_valid    = out_valid_q;
	assign status       = status_q;
	assign granted_slot = granted_q;
	assign preempted    = preempted_q;

endmodule
